// ===== rtl/mtf_pkg.sv =====
// Shared types and constants for the multiframe telegram filter.
// Used by every module in rtl/; depends on nothing.
package mtf_pkg;

	localparam int SLOTS     = 8;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W      = 32;
	localparam int TG_W      = 8;
	localparam int TMR_W     = 8;
	localparam int FRM_W     = 8;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	localparam logic OP_TELEGRAM = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	localparam logic KIND_SINGLE = 1'b0;
	localparam logic KIND_MULTI  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIME  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAMES = 1'b1;

	localparam logic [TMR_W-1:0] LOCK_TIME_RST  = 8'd10;
	localparam logic [FRM_W-1:0] MAX_FRAMES_RST = 8'd3;
	localparam logic [FRM_W-1:0] FRM_ONE        = 8'd1;
	localparam logic [FRM_W-1:0] FRM_SAT        = 8'hFF;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic [ID_W-1:0]  sensor_id;
		logic [TMR_W-1:0] lock_timer;
		logic [FRM_W-1:0] frame_count;
		logic [TG_W-1:0]  tg_count;
	} slot_t;

	typedef struct packed {
		logic id_match;
		logic id_zero;
		logic timer_zero;
		logic tg_differs;
		logic tg_same;
		logic frames_below;
		logic frames_full;
	} cmp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_TICK
	} state_t;

endpackage

// ===== rtl/mtf_table.sv =====
// Slot table: SLOTS entries in flops, one write port, one read port.
// Depends on mtf_pkg.
module mtf_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  mtf_pkg::slot_idx_t waddr,
	input  mtf_pkg::slot_t    wdata,
	input  mtf_pkg::slot_idx_t raddr,
	output mtf_pkg::slot_t    rdata
);

	mtf_pkg::slot_t slots_q [mtf_pkg::SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mtf_pkg::SLOTS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (we) begin
			slots_q[waddr] <= wdata;
		end
	end

	assign rdata = slots_q[raddr];

endmodule

// ===== rtl/mtf_cmp.sv =====
// Shared compare unit: evaluates one slot entry against the current item.
// Depends on mtf_pkg.
module mtf_cmp (
	input  mtf_pkg::slot_t                    entry,
	input  logic [mtf_pkg::ID_W-1:0]          sensor_id,
	input  logic [mtf_pkg::TG_W-1:0]          tg,
	input  logic [mtf_pkg::FRM_W-1:0]         max_frames,
	output mtf_pkg::cmp_t                     flags
);

	logic tg_valid;

	assign tg_valid = (tg != '0);

	always_comb begin
		flags.id_match     = (entry.sensor_id == sensor_id);
		flags.id_zero      = (entry.sensor_id == '0);
		flags.timer_zero   = (entry.lock_timer == '0);
		flags.tg_differs   = tg_valid && (entry.tg_count != tg);
		flags.tg_same      = tg_valid && (entry.tg_count == tg);
		flags.frames_below = (entry.frame_count < max_frames);
		flags.frames_full  = (entry.frame_count == mtf_pkg::FRM_SAT);
	end

endmodule

// ===== rtl/multiframe_telegram_filter.sv =====
// Top level of the multiframe telegram filter: sequencer, config registers.
// Depends on mtf_pkg, mtf_table and mtf_cmp.
//
// Usage:
//   An item (opcode, sensor_id, telegram_counter) is taken at a rising edge
//   with start high and busy low. busy stays high until the item is done.
//   A telegram walks the slot table one slot per cycle through a single
//   compare unit and stops at the first slot whose ID matches; it then
//   updates the chosen slot in ST_UPDATE and gives its result. When no
//   matching and no usable slot is found, the result is given at the end
//   of the walk, without an update.
//   A tick walks all SLOTS slots, decrementing nonzero lock timers, and
//   gives no result; busy stays high for the whole walk.
//   A result is frame_kind with done high for exactly one cycle; the
//   receiver cannot stall, so nothing is held back. The next item may be
//   taken on the edge that ends the done cycle.
//   Config writes (cfg_we, cfg_idx, cfg_data) take effect at once; write
//   only while idle. Reset clears the table and restores lock_time 10 and
//   max_frames 3.
module multiframe_telegram_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            opcode,
	input  logic [mtf_pkg::ID_W-1:0]        sensor_id,
	input  logic [mtf_pkg::TG_W-1:0]        telegram_counter,
	output logic                            done,
	output logic                            frame_kind,
	input  logic                            cfg_we,
	input  logic [mtf_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [mtf_pkg::CFG_W-1:0]       cfg_data
);

	mtf_pkg::state_t            state_q, state_d;
	mtf_pkg::slot_idx_t         idx_q, found_q, empty_q, idle_q;
	logic                       empty_vld_q, idle_vld_q;
	logic [mtf_pkg::ID_W-1:0]   id_q;
	logic [mtf_pkg::TG_W-1:0]   tg_q;
	logic [mtf_pkg::TMR_W-1:0]  lock_time_q;
	logic [mtf_pkg::FRM_W-1:0]  max_frames_q;
	logic                       done_q, kind_q;

	mtf_pkg::slot_idx_t         raddr;
	mtf_pkg::slot_t             entry;
	mtf_pkg::cmp_t              flags;
	logic                       tbl_we;
	mtf_pkg::slot_t             tbl_wdata;
	mtf_pkg::slot_idx_t         tbl_waddr;
	logic                       done_d, kind_d;
	logic                       accept, last, any_slot;

	assign accept   = start && (state_q == mtf_pkg::ST_IDLE);
	assign last     = (idx_q == mtf_pkg::SLOT_LAST);
	assign any_slot = empty_vld_q || flags.id_zero || idle_vld_q || flags.timer_zero;
	assign raddr    = (state_q == mtf_pkg::ST_UPDATE) ? found_q : idx_q;

	mtf_table u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (raddr),
		.rdata (entry)
	);

	mtf_cmp u_cmp (
		.entry     (entry),
		.sensor_id (id_q),
		.tg        (tg_q),
		.max_frames(max_frames_q),
		.flags     (flags)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mtf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (opcode == mtf_pkg::OP_TICK) ? mtf_pkg::ST_TICK : mtf_pkg::ST_SCAN;
				end
			end
			mtf_pkg::ST_SCAN: begin
				if (flags.id_match) begin
					state_d = mtf_pkg::ST_UPDATE;
				end else if (last) begin
					state_d = any_slot ? mtf_pkg::ST_UPDATE : mtf_pkg::ST_IDLE;
				end
			end
			mtf_pkg::ST_UPDATE: begin
				state_d = mtf_pkg::ST_IDLE;
			end
			mtf_pkg::ST_TICK: begin
				if (last) begin
					state_d = mtf_pkg::ST_IDLE;
				end
			end
			default: state_d = mtf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = idx_q;
		tbl_wdata = entry;
		done_d    = 1'b0;
		kind_d    = mtf_pkg::KIND_SINGLE;
		case (state_q)
			mtf_pkg::ST_SCAN: begin
				if (!flags.id_match && last && !any_slot) begin
					done_d = 1'b1;
				end
			end
			mtf_pkg::ST_UPDATE: begin
				done_d    = 1'b1;
				tbl_waddr = found_q;
				if (flags.timer_zero || flags.tg_differs) begin
					tbl_we                = 1'b1;
					tbl_wdata.sensor_id   = id_q;
					tbl_wdata.lock_timer  = lock_time_q;
					tbl_wdata.frame_count = mtf_pkg::FRM_ONE;
					tbl_wdata.tg_count    = tg_q;
				end else if (flags.frames_below || flags.tg_same) begin
					kind_d = mtf_pkg::KIND_MULTI;
					if (!flags.frames_full) begin
						tbl_we                = 1'b1;
						tbl_wdata.frame_count = entry.frame_count + mtf_pkg::FRM_ONE;
					end
				end
			end
			mtf_pkg::ST_TICK: begin
				if (!flags.timer_zero) begin
					tbl_we               = 1'b1;
					tbl_wdata.lock_timer = entry.lock_timer - 1'b1;
				end
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtf_pkg::ST_IDLE;
			idx_q       <= '0;
			empty_vld_q <= 1'b0;
			idle_vld_q  <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (accept) begin
				idx_q       <= '0;
				empty_vld_q <= 1'b0;
				idle_vld_q  <= 1'b0;
			end else if (state_q == mtf_pkg::ST_SCAN || state_q == mtf_pkg::ST_TICK) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
				if (flags.id_zero) begin
					empty_vld_q <= 1'b1;
				end
				if (flags.timer_zero) begin
					idle_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		if (accept) begin
			id_q <= sensor_id;
			tg_q <= telegram_counter;
		end
		if (state_q == mtf_pkg::ST_SCAN) begin
			if (!empty_vld_q && flags.id_zero) begin
				empty_q <= idx_q;
			end
			if (!idle_vld_q && flags.timer_zero) begin
				idle_q <= idx_q;
			end
			if (flags.id_match) begin
				found_q <= idx_q;
			end else if (last) begin
				if (empty_vld_q) begin
					found_q <= empty_q;
				end else if (flags.id_zero) begin
					found_q <= idx_q;
				end else if (idle_vld_q) begin
					found_q <= idle_q;
				end else begin
					found_q <= idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_time_q  <= mtf_pkg::LOCK_TIME_RST;
			max_frames_q <= mtf_pkg::MAX_FRAMES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				mtf_pkg::REG_LOCK_TIME:  lock_time_q  <= cfg_data;
				mtf_pkg::REG_MAX_FRAMES: max_frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy       = (state_q != mtf_pkg::ST_IDLE);
	assign done       = done_q;
	assign frame_kind = kind_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == mtf_pkg::ST_IDLE))
		else $error("result strobe while sequencer busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtf_pkg::ST_TICK) |=> !done)
		else $error("tick produced a result");

	a_multi_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		(done && frame_kind == mtf_pkg::KIND_MULTI) |-> $past(state_q == mtf_pkg::ST_UPDATE))
		else $error("multi result without slot update");

endmodule
